// ===== rtl/vubp_pkg.sv =====
// Package for the unit header parser: phase codes, result kinds,
// configuration register indexes and the result record type.
// No dependencies.
`default_nettype none

package vubp_pkg;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_SEQ_H   = 3'd1,
        PH_SEQ_W   = 3'd2,
        PH_SEQ_F   = 3'd3,
        PH_FR_QP   = 3'd4,
        PH_FR_LEN  = 3'd5,
        PH_PAYLOAD = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        KIND_SEQ     = 3'd0,
        KIND_FRAME   = 3'd1,
        KIND_PAYLOAD = 3'd2,
        KIND_UNKNOWN = 3'd3,
        KIND_TRUNC   = 3'd4
    } t_kind;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_SEQ_TYPE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTRA_TYPE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTER_TYPE = 2'd2;

    localparam int unsigned VAL_W   = 30;
    localparam int unsigned QDEPTH  = 3;
    localparam int unsigned TDATA_W = 120;

    typedef struct packed {
        t_kind             kind;
        logic [3:0]        unit_type;
        logic [3:0]        param_set_id;
        logic [VAL_W-1:0]  pic_height;
        logic [VAL_W-1:0]  pic_width;
        logic              split_entropy;
        logic              adaptive_intra;
        logic [7:0]        frame_qp;
        logic [VAL_W-1:0]  payload_length;
        logic [7:0]        data_byte;
        logic              last_payload;
        logic              last_of_item;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/video_unit_bitstream_parser.sv =====
// Unit header parser top level: byte stream in, parsed result words out.
// Depends on vubp_pkg.
//
// Usage:
//   The slave channel takes one stream byte per word in s_axis_tdata[7:0];
//   s_axis_tlast marks the last byte of a buffer. Each accepted byte is
//   parsed in the cycle it is taken and produces zero, one or two result
//   words, which go into a three-entry output queue. The master channel
//   carries the result kind in m_axis_tuser, the end of a frame payload in
//   m_axis_tlast and the remaining fields in m_axis_tdata.
//   Result words are registered in the output queue before they reach
//   the master side. Throughput is one byte per cycle while bytes give at
//   most one result each and the receiver takes every word; the queue
//   drains one word per cycle, so a byte that gives two results (a result
//   followed by a truncation error) holds off the next byte. s_axis_tready
//   is high while the queue holds at most one word.
//   Reset (synchronous, active low) empties the queue, returns the parser
//   to waiting for a unit header and loads the type code registers with
//   0, 1 and 2. When the receiver stalls, the queue fills and s_axis_tready
//   drops; no word is lost. The user writes the type code registers through
//   the configuration port only while the parser is idle; nothing checks it.
`default_nettype none

module video_unit_bitstream_parser
    import vubp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Configuration write port.
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // Byte input channel.
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,  // [7:0] byte_in
    input  wire logic                  s_axis_tlast,  // stream_end
    // Result channel.
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [3:0] unit_type, [7:4] param_set_id, [37:8] pic_height,
    // [67:38] pic_width, [68] split_entropy, [69] adaptive_intra,
    // [77:70] frame_qp, [107:78] payload_length, [115:108] data_byte,
    // [116] last_of_item, [119:117] zero
    output logic [TDATA_W-1:0]         m_axis_tdata,
    output logic [2:0]                 m_axis_tuser,  // [2:0] kind
    output logic                       m_axis_tlast   // last_payload
);

    // Configuration registers.
    logic [3:0] r_seq_code;
    logic [3:0] r_intra_code;
    logic [3:0] r_inter_code;

    // Parser state.
    t_phase            r_phase,        n_phase;
    logic [VAL_W-1:0]  r_acc,          n_acc;
    logic [1:0]        r_vleft,        n_vleft;
    logic [3:0]        r_held_type,    n_held_type;
    logic [3:0]        r_held_id,      n_held_id;
    logic [VAL_W-1:0]  r_held_height,  n_held_height;
    logic [VAL_W-1:0]  r_held_width,   n_held_width;
    logic [7:0]        r_held_qp,      n_held_qp;
    logic [VAL_W-1:0]  r_payload_left, n_payload_left;

    // Output queue, entry 0 is the head.
    t_result           r_q [QDEPTH];
    t_result           n_q [QDEPTH];
    logic [1:0]        r_cnt, n_cnt;

    logic              s_accept;
    logic              m_pop;
    logic [7:0]        b;

    // Varint step.
    logic              v_done;
    logic [VAL_W-1:0]  v_acc;
    logic [1:0]        v_left;

    t_result           prim, trunc, slot0, slot1;
    logic              prim_v, trunc_v, open_unit;
    logic              slot0_v, slot1_v;
    logic [1:0]        base;

    assign b             = s_axis_tdata;
    assign s_axis_tready = (r_cnt <= 2'd1);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_pop         = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_code   <= 4'd0;
            r_intra_code <= 4'd1;
            r_inter_code <= 4'd2;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_SEQ_TYPE:   r_seq_code   <= i_cfg_wdata;
                CFG_INTRA_TYPE: r_intra_code <= i_cfg_wdata;
                CFG_INTER_TYPE: r_inter_code <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // A varint byte either starts a value (top bit 0 is a one-byte value,
    // 10 and 11 announce one or three more bytes) or shifts in eight bits.
    always_comb begin
        v_done = 1'b0;
        v_acc  = r_acc;
        v_left = r_vleft;
        if (r_vleft == 2'd0) begin
            if (!b[7]) begin
                v_done = 1'b1;
                v_acc  = {{(VAL_W-8){1'b0}}, b};
            end else begin
                v_acc  = {{(VAL_W-6){1'b0}}, b[5:0]};
                v_left = b[6] ? 2'd3 : 2'd1;
            end
        end else begin
            v_acc  = {r_acc[VAL_W-9:0], b};
            v_left = r_vleft - 2'd1;
            v_done = (r_vleft == 2'd1);
        end
    end

    always_comb begin
        n_phase        = r_phase;
        n_acc          = r_acc;
        n_vleft        = r_vleft;
        n_held_type    = r_held_type;
        n_held_id      = r_held_id;
        n_held_height  = r_held_height;
        n_held_width   = r_held_width;
        n_held_qp      = r_held_qp;
        n_payload_left = r_payload_left;
        prim           = '0;
        prim_v         = 1'b0;
        open_unit      = 1'b1;
        trunc          = '0;
        trunc_v        = 1'b0;

        if (s_accept) begin
            case (r_phase)
                PH_HEADER: begin
                    n_held_type = b[7:4];
                    n_held_id   = b[3:0];
                    n_acc       = '0;
                    n_vleft     = 2'd0;
                    // The sequence code takes priority over the frame codes.
                    if (b[7:4] == r_seq_code) begin
                        n_phase = PH_SEQ_H;
                    end else if (b[7:4] == r_intra_code || b[7:4] == r_inter_code) begin
                        n_phase = PH_FR_QP;
                    end else begin
                        prim_v    = 1'b1;
                        prim.kind = KIND_UNKNOWN;
                        open_unit = 1'b0;
                    end
                end
                PH_SEQ_H: begin
                    n_acc   = v_acc;
                    n_vleft = v_left;
                    if (v_done) begin
                        n_held_height = v_acc;
                        n_acc         = '0;
                        n_phase       = PH_SEQ_W;
                    end
                end
                PH_SEQ_W: begin
                    n_acc   = v_acc;
                    n_vleft = v_left;
                    if (v_done) begin
                        n_held_width = v_acc;
                        n_acc        = '0;
                        n_phase      = PH_SEQ_F;
                    end
                end
                PH_SEQ_F: begin
                    prim_v              = 1'b1;
                    prim.kind           = KIND_SEQ;
                    prim.pic_height     = r_held_height;
                    prim.pic_width      = r_held_width;
                    prim.split_entropy  = b[2];
                    prim.adaptive_intra = b[0];
                    n_phase             = PH_HEADER;
                    open_unit           = 1'b0;
                end
                PH_FR_QP: begin
                    n_held_qp = b;
                    n_phase   = PH_FR_LEN;
                end
                PH_FR_LEN: begin
                    n_acc   = v_acc;
                    n_vleft = v_left;
                    if (v_done) begin
                        n_payload_left      = v_acc;
                        n_acc               = '0;
                        prim_v              = 1'b1;
                        prim.kind           = KIND_FRAME;
                        prim.frame_qp       = r_held_qp;
                        prim.payload_length = v_acc;
                        if (v_acc == '0) begin
                            n_phase   = PH_HEADER;
                            open_unit = 1'b0;
                        end else begin
                            n_phase   = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    prim_v            = 1'b1;
                    prim.kind         = KIND_PAYLOAD;
                    prim.data_byte    = b;
                    prim.last_payload = (r_payload_left <= 30'd1);
                    if (r_payload_left <= 30'd1) begin
                        n_payload_left = '0;
                        n_phase        = PH_HEADER;
                        open_unit      = 1'b0;
                    end else begin
                        n_payload_left = r_payload_left - 30'd1;
                    end
                end
                default: begin
                    n_phase   = PH_HEADER;
                    open_unit = 1'b0;
                end
            endcase

            prim.unit_type    = n_held_type;
            prim.param_set_id = n_held_id;

            // The buffer ended inside a unit: report it and start over.
            if (s_axis_tlast && open_unit) begin
                trunc_v            = 1'b1;
                trunc.kind         = KIND_TRUNC;
                trunc.unit_type    = n_held_type;
                trunc.param_set_id = n_held_id;
                n_phase            = PH_HEADER;
                n_acc              = '0;
                n_vleft            = 2'd0;
                n_payload_left     = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HEADER;
            r_acc          <= '0;
            r_vleft        <= 2'd0;
            r_held_type    <= 4'd0;
            r_held_id      <= 4'd0;
            r_held_height  <= '0;
            r_held_width   <= '0;
            r_held_qp      <= 8'd0;
            r_payload_left <= '0;
        end else begin
            r_phase        <= n_phase;
            r_acc          <= n_acc;
            r_vleft        <= n_vleft;
            r_held_type    <= n_held_type;
            r_held_id      <= n_held_id;
            r_held_height  <= n_held_height;
            r_held_width   <= n_held_width;
            r_held_qp      <= n_held_qp;
            r_payload_left <= n_payload_left;
        end
    end

    // Queue update: shift on pop, then write new words behind what remains.
    always_comb begin
        base    = r_cnt - {1'b0, m_pop};
        slot0   = prim_v ? prim : trunc;
        slot0_v = prim_v || trunc_v;
        slot1   = trunc;
        slot1_v = prim_v && trunc_v;
        slot0.last_of_item = !slot1_v;
        slot1.last_of_item = 1'b1;

        for (int i = 0; i < QDEPTH; i++) begin
            n_q[i] = r_q[i];
            if (m_pop && (i < QDEPTH - 1)) begin
                n_q[i] = r_q[(i + 1) % QDEPTH];
            end
            if (slot0_v && base == 2'(i)) begin
                n_q[i] = slot0;
            end
            if (slot1_v && 2'(base + 2'd1) == 2'(i)) begin
                n_q[i] = slot1;
            end
        end

        n_cnt = base + {1'b0, slot0_v} + {1'b0, slot1_v};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QDEPTH; i++) begin
            r_q[i] <= n_q[i];
        end
    end

    assign m_axis_tuser = r_q[0].kind;
    assign m_axis_tlast = r_q[0].last_payload;
    assign m_axis_tdata = {3'd0,
                           r_q[0].last_of_item,
                           r_q[0].data_byte,
                           r_q[0].payload_length,
                           r_q[0].frame_qp,
                           r_q[0].adaptive_intra,
                           r_q[0].split_entropy,
                           r_q[0].pic_width,
                           r_q[0].pic_height,
                           r_q[0].param_set_id,
                           r_q[0].unit_type};

    // The queue never holds more words than it has entries.
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(QDEPTH))
        else $error("output queue overflow");

    // Every buffer end leaves the parser waiting for a header.
    a_end_to_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && s_axis_tlast) |=> (r_phase == PH_HEADER))
        else $error("parser not back at header after stream end");

    // A payload phase always has bytes still to come.
    a_payload_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_payload_left != '0))
        else $error("payload phase with zero bytes left");

    // A pending multi-byte varint exists only in a varint phase.
    a_varint_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vleft != 2'd0) |->
            (r_phase == PH_SEQ_H || r_phase == PH_SEQ_W || r_phase == PH_FR_LEN))
        else $error("varint bytes pending outside a varint phase");

    // A stalled result word stays on the bus unchanged until it is taken.
    a_hold_until_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result word changed before it was taken");

endmodule

`default_nettype wire

// ===== dv/vubp_parse_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the unit header parser: follows the byte and result channels
// and the configuration port, predicts every result word and compares it.
// Depends on vubp_pkg.

module vubp_parse_checker
    import vubp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                  i_s_tvalid,
    input  wire logic                  i_s_tready,
    input  wire logic [7:0]            i_s_tdata,   // [7:0] byte_in
    input  wire logic                  i_s_tlast,   // stream_end
    input  wire logic                  i_m_tvalid,
    input  wire logic                  i_m_tready,
    // [3:0] unit_type, [7:4] param_set_id, [37:8] pic_height,
    // [67:38] pic_width, [68] split_entropy, [69] adaptive_intra,
    // [77:70] frame_qp, [107:78] payload_length, [115:108] data_byte,
    // [116] last_of_item
    input  wire logic [TDATA_W-1:0]    i_m_tdata,
    input  wire logic [2:0]            i_m_tuser,   // [2:0] kind
    input  wire logic                  i_m_tlast,   // last_payload
    output int                         o_fail_count,
    output int                         o_pending
);

    localparam int MAX_REPORTS = 10;

    // Parser state as the predictor sees it.
    t_phase           ph;
    logic [VAL_W-1:0] vi_acc;
    logic [1:0]       vi_left;
    logic [3:0]       h_type;
    logic [3:0]       h_id;
    logic [VAL_W-1:0] h_height;
    logic [VAL_W-1:0] h_width;
    logic [7:0]       h_qp;
    logic [VAL_W-1:0] pay_left;
    logic [3:0]       cfg_seq;
    logic [3:0]       cfg_intra;
    logic [3:0]       cfg_inter;

    t_result predicted_results[$];
    t_result seen;
    t_result want;
    int      mismatches = 0;

    function automatic string fmt_result(t_result r);
        return $sformatf({"kind=%0d type=%h id=%h height=%h width=%h split=%b adapt=%b",
                          " qp=%h len=%h data=%h last_pay=%b last_item=%b"},
                         r.kind, r.unit_type, r.param_set_id, r.pic_height, r.pic_width,
                         r.split_entropy, r.adaptive_intra, r.frame_qp, r.payload_length,
                         r.data_byte, r.last_payload, r.last_of_item);
    endfunction

    function automatic t_result header_result(t_kind k);
        t_result r;
        r = '0;
        r.kind = k;
        r.unit_type = h_type;
        r.param_set_id = h_id;
        return r;
    endfunction

    // One byte of a prefixed varint; done is set once the value is complete.
    task automatic take_varint(input logic [7:0] b, output bit done);
        done = 1'b0;
        if (vi_left == 2'd0) begin
            if (!b[7]) begin
                vi_acc = {22'd0, b};
                done = 1'b1;
            end else begin
                vi_acc = {24'd0, b[5:0]};
                vi_left = (b[7:6] == 2'b10) ? 2'd1 : 2'd3;
            end
        end else begin
            vi_acc = {vi_acc[21:0], b};
            vi_left = vi_left - 2'd1;
            done = (vi_left == 2'd0);
        end
    endtask

    task automatic parse_stream_byte(input logic [7:0] b, input logic fin);
        t_result step_res[2];
        t_result r;
        int      n;
        bit      open;
        bit      done;
        n = 0;
        open = 1'b1;
        case (ph)
            PH_HEADER: begin
                h_type = b[7:4];
                h_id = b[3:0];
                vi_acc = '0;
                vi_left = '0;
                // The sequence code has priority over the frame codes.
                if (h_type == cfg_seq) begin
                    ph = PH_SEQ_H;
                end else if (h_type == cfg_intra || h_type == cfg_inter) begin
                    ph = PH_FR_QP;
                end else begin
                    step_res[n] = header_result(KIND_UNKNOWN);
                    n++;
                    open = 1'b0;
                end
            end
            PH_SEQ_H: begin
                take_varint(b, done);
                if (done) begin
                    h_height = vi_acc;
                    vi_acc = '0;
                    ph = PH_SEQ_W;
                end
            end
            PH_SEQ_W: begin
                take_varint(b, done);
                if (done) begin
                    h_width = vi_acc;
                    vi_acc = '0;
                    ph = PH_SEQ_F;
                end
            end
            PH_SEQ_F: begin
                r = header_result(KIND_SEQ);
                r.pic_height = h_height;
                r.pic_width = h_width;
                r.split_entropy = b[2];
                r.adaptive_intra = b[0];
                step_res[n] = r;
                n++;
                ph = PH_HEADER;
                open = 1'b0;
            end
            PH_FR_QP: begin
                h_qp = b;
                ph = PH_FR_LEN;
            end
            PH_FR_LEN: begin
                take_varint(b, done);
                if (done) begin
                    pay_left = vi_acc;
                    vi_acc = '0;
                    r = header_result(KIND_FRAME);
                    r.frame_qp = h_qp;
                    r.payload_length = pay_left;
                    step_res[n] = r;
                    n++;
                    if (pay_left == '0) begin
                        ph = PH_HEADER;
                        open = 1'b0;
                    end else begin
                        ph = PH_PAYLOAD;
                    end
                end
            end
            default: begin
                r = header_result(KIND_PAYLOAD);
                r.data_byte = b;
                r.last_payload = (pay_left <= 30'd1);
                if (pay_left != '0) pay_left = pay_left - 30'd1;
                step_res[n] = r;
                n++;
                if (pay_left == '0) begin
                    ph = PH_HEADER;
                    open = 1'b0;
                end
            end
        endcase
        // The buffer ran out with a unit still open.
        if (fin && open) begin
            step_res[n] = header_result(KIND_TRUNC);
            n++;
            ph = PH_HEADER;
            vi_acc = '0;
            vi_left = '0;
            pay_left = '0;
        end
        if (n > 0) step_res[n-1].last_of_item = 1'b1;
        for (int i = 0; i < n; i++) predicted_results.push_back(step_res[i]);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ph = PH_HEADER;
            vi_acc = '0;
            vi_left = '0;
            h_type = '0;
            h_id = '0;
            h_height = '0;
            h_width = '0;
            h_qp = '0;
            pay_left = '0;
            cfg_seq = 4'd0;
            cfg_intra = 4'd1;
            cfg_inter = 4'd2;
            predicted_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                seen = '0;
                seen.kind = t_kind'(i_m_tuser);
                seen.unit_type = i_m_tdata[3:0];
                seen.param_set_id = i_m_tdata[7:4];
                seen.pic_height = i_m_tdata[37:8];
                seen.pic_width = i_m_tdata[67:38];
                seen.split_entropy = i_m_tdata[68];
                seen.adaptive_intra = i_m_tdata[69];
                seen.frame_qp = i_m_tdata[77:70];
                seen.payload_length = i_m_tdata[107:78];
                seen.data_byte = i_m_tdata[115:108];
                seen.last_payload = i_m_tlast;
                seen.last_of_item = i_m_tdata[116];
                if (predicted_results.size() == 0) begin
                    if (mismatches < MAX_REPORTS)
                        $display("Result word with nothing predicted: %s", fmt_result(seen));
                    mismatches++;
                end else begin
                    want = predicted_results.pop_front();
                    if (seen !== want) begin
                        if (mismatches < MAX_REPORTS) begin
                            $display("Result mismatch, expected %s", fmt_result(want));
                            $display("                 actual   %s", fmt_result(seen));
                        end
                        mismatches++;
                    end
                end
            end
            if (i_cfg_wr_en) begin
                // The spare index has no register behind it.
                case (i_cfg_index)
                    CFG_SEQ_TYPE:   cfg_seq = i_cfg_wdata;
                    CFG_INTRA_TYPE: cfg_intra = i_cfg_wdata;
                    CFG_INTER_TYPE: cfg_inter = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) parse_stream_byte(i_s_tdata, i_s_tlast);
        end
        o_pending <= predicted_results.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== dv/video_unit_bitstream_parser_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the unit header parser: drives coded byte streams and
// type code settings, and gives the verdict. Depends on vubp_pkg,
// video_unit_bitstream_parser and vubp_parse_checker.

module video_unit_bitstream_parser_tb;
    import vubp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RESET_CYCLES   = 11;
    localparam int SETTLE_CYCLES  = 16;
    localparam int PHASE_BYTES    = 170;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]    m_axis_tdata;
    logic [2:0]            m_axis_tuser;
    logic                  m_axis_tlast;
    int                    fail_count;
    int                    pending_results;

    // Type codes currently programmed, used to build well-formed units.
    logic [3:0] cur_seq = 4'd0;
    logic [3:0] cur_intra = 4'd1;
    logic [3:0] cur_inter = 4'd2;
    logic [7:0] unit_bytes[$];
    int         sent_bytes = 0;
    int         idle_cycles = 0;
    bit         quiet = 1'b0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    video_unit_bitstream_parser DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_index   (cfg_index),
        .i_cfg_wdata   (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    vubp_parse_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_index  (cfg_index),
        .i_cfg_wdata  (cfg_wdata),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tlast    (s_axis_tlast),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .i_m_tlast    (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
        $display("Verification failed");
        $finish;
    end

    // Receiver: a random stall, sometimes none, before every result word.
    initial begin : result_sink
        int gap;
        forever begin
            gap = quiet ? 0 : $urandom_range(0, 17);
            @(negedge clk);
            if (gap != 0) begin
                m_axis_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid) @(posedge clk);
        end
    end

    task automatic send_byte(input logic [7:0] b, input bit fin);
        int gap;
        // Every so often both sides run back to back for a while.
        if (sent_bytes % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
        gap = quiet ? 0 : $urandom_range(0, 17);
        @(negedge clk);
        if (gap != 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = b;
        s_axis_tlast = fin;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sent_bytes++;
    endtask

    // Sends the built unit up to byte cut; fin marks that byte as the end of the buffer.
    task automatic send_unit(input int cut, input bit fin);
        for (int i = 0; i <= cut; i++) send_byte(unit_bytes[i], fin && (i == cut));
        unit_bytes.delete();
    endtask

    // form 0: one byte, form 1: two bytes, form 2: four bytes.
    task automatic add_varint(input logic [29:0] v, input int form);
        case (form)
            0: unit_bytes.push_back({1'b0, v[6:0]});
            1: begin
                unit_bytes.push_back({2'b10, v[13:8]});
                unit_bytes.push_back(v[7:0]);
            end
            default: begin
                unit_bytes.push_back({2'b11, v[29:24]});
                unit_bytes.push_back(v[23:16]);
                unit_bytes.push_back(v[15:8]);
                unit_bytes.push_back(v[7:0]);
            end
        endcase
    endtask

    function automatic logic [29:0] rand_fit(int form);
        case (form)
            0: return 30'($urandom_range(0, 127));
            1: return 30'($urandom_range(0, 16383));
            default: begin
                case ($urandom_range(0, 3))
                    0: return 30'd0;
                    1: return 30'h3FFFFFFF;
                    default: return 30'($urandom);
                endcase
            end
        endcase
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [3:0] v);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = v;
        @(posedge clk);
    endtask

    task automatic apply_config(input logic [3:0] seq, input logic [3:0] intra,
                                input logic [3:0] inter);
        cfg_write(CFG_SEQ_TYPE, seq);
        cfg_write(CFG_INTRA_TYPE, intra);
        cfg_write(CFG_INTER_TYPE, inter);
        cfg_write(CFG_IDX_UNUSED, 4'($urandom));
        @(negedge clk);
        cfg_wr_en = 1'b0;
        cur_seq = seq;
        cur_intra = intra;
        cur_inter = inter;
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly well-formed units with random content, some cut short, some noise.
    task automatic run_random_phase(input int n_bytes);
        int         start;
        int         pick;
        int         form;
        int         cut;
        int         n_pay;
        bit         fin;
        bit         force_cut;
        logic [29:0] len;
        logic [3:0]  t;
        start = sent_bytes;
        while (sent_bytes - start < n_bytes) begin
            pick = $urandom_range(0, 99);
            force_cut = 1'b0;
            if (pick < 30) begin
                unit_bytes.push_back({cur_seq, 4'($urandom)});
                form = $urandom_range(0, 2);
                add_varint(rand_fit(form), form);
                form = $urandom_range(0, 2);
                add_varint(rand_fit(form), form);
                unit_bytes.push_back(8'($urandom));
            end else if (pick < 72) begin
                t = pick[0] ? cur_intra : cur_inter;
                unit_bytes.push_back({t, 4'($urandom)});
                unit_bytes.push_back(8'($urandom));
                if ($urandom_range(0, 11) == 0) begin
                    // A huge length is only ever started, then the buffer ends.
                    len = 30'($urandom) | 30'h400;
                    form = 2;
                    n_pay = $urandom_range(0, 6);
                    force_cut = 1'b1;
                end else begin
                    len = ($urandom_range(0, 4) == 0) ? 30'($urandom_range(0, 40))
                                                      : 30'($urandom_range(0, 6));
                    form = $urandom_range(0, 2);
                    n_pay = int'(len);
                end
                add_varint(len, form);
                repeat (n_pay) unit_bytes.push_back(8'($urandom));
            end else if (pick < 84) begin
                do t = 4'($urandom);
                while (t == cur_seq || t == cur_intra || t == cur_inter);
                unit_bytes.push_back({t, 4'($urandom)});
            end else begin
                repeat ($urandom_range(1, 4)) unit_bytes.push_back(8'($urandom));
            end
            cut = unit_bytes.size() - 1;
            fin = ($urandom_range(0, 9) == 0);
            if (force_cut) begin
                fin = 1'b1;
            end else if ($urandom_range(0, 6) == 0) begin
                cut = $urandom_range(0, cut);
                fin = 1'b1;
            end
            send_unit(cut, fin);
        end
        // A final end-of-buffer byte leaves the parser waiting for a header.
        unit_bytes.push_back(8'($urandom));
        send_unit(0, 1'b1);
        drain_results();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset codes: sequence 0, intra 1, inter 2.
        unit_bytes = '{8'h0F, 8'h00, 8'h7F, 8'h05};
        send_unit(3, 1'b0);
        // Widest varints: four bytes of all ones for the height, two for the width.
        unit_bytes.push_back(8'h0A);
        add_varint(30'h3FFFFFFF, 2);
        add_varint(30'h3FFF, 1);
        unit_bytes.push_back(8'hFA);
        send_unit(7, 1'b0);
        // Intra frame with an empty payload.
        unit_bytes = '{8'h1F, 8'hFF, 8'h00};
        send_unit(2, 1'b0);
        // Inter frame whose buffer ends on its last payload byte: no truncation.
        unit_bytes = '{8'h20, 8'h00, 8'h80, 8'h02, 8'h00, 8'hFF};
        send_unit(5, 1'b1);
        // Unknown type at the end of a buffer, then a bare known header.
        unit_bytes = '{8'hF3};
        send_unit(0, 1'b1);
        unit_bytes = '{8'h15};
        send_unit(0, 1'b1);
        // Buffer ends on a payload byte of an open frame: two words from one byte.
        unit_bytes = '{8'h2C, 8'h80, 8'h03, 8'hAA};
        send_unit(3, 1'b1);
        drain_results();

        apply_config(4'd15, 4'd0, 4'd7);
        run_random_phase(PHASE_BYTES);
        apply_config(4'd0, 4'd15, 4'd15);
        run_random_phase(PHASE_BYTES);
        // All three codes equal: every known header opens a sequence unit.
        apply_config(4'd9, 4'd9, 4'd9);
        run_random_phase(PHASE_BYTES);
        repeat (2) begin
            apply_config(4'($urandom), 4'($urandom), 4'($urandom));
            run_random_phase(PHASE_BYTES);
        end
        apply_config(4'd3, 4'd15, 4'd0);
        run_random_phase(PHASE_BYTES);

        if (fail_count == 0 && pending_results == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
